// ===== src/hnt_pkg.sv =====
// Shared widths for the heightmap normal and tangent pipeline.
package hnt_pkg;
    localparam int OUT_FRAC_BITS = 14;
    localparam int HEIGHT_W = 16;
    localparam int DIFF_W   = 17;
    localparam int SQ_W     = 34;
    localparam int SUM_W    = 36;
    localparam int GRID_W   = 6;
    localparam int SCOMP_W  = OUT_FRAC_BITS + 2;
    localparam int UCOMP_W  = OUT_FRAC_BITS + 1;
endpackage

// ===== src/hnt_unit.sv =====
// Pipelined digit-by-digit unit: round(m * 2^F / sqrt(s)), one quotient bit per stage.
module hnt_unit #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic [hnt_pkg::SQ_W-1:0]      i_m2,
    input  logic [hnt_pkg::SUM_W-1:0]     i_s,
    input  logic                          i_neg,
    output logic [OUT_FRAC_BITS+1:0]      o_mag,
    output logic                          o_neg
);
    localparam int NS = OUT_FRAC_BITS + 2;
    localparam int W  = 2 * NS + hnt_pkg::SUM_W + 4;

    logic signed [W-1:0] r_e [1:NS];
    logic signed [W-1:0] r_b [1:NS];
    logic signed [W-1:0] r_s [1:NS];
    logic [NS-1:0]       r_q [1:NS];
    logic                r_neg [1:NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = NS - 1 - k;
        logic signed [W-1:0] s_e, s_b, s_s;
        logic [NS-1:0]       s_q;
        logic                s_neg;
        logic signed [W-1:0] n_t;
        logic                n_take;

        if (k == 0) begin : g_first
            assign s_e   = $signed(W'(i_m2)) <<< (2 * OUT_FRAC_BITS + 2);
            assign s_b   = '0;
            assign s_s   = $signed(W'(i_s));
            assign s_q   = '0;
            assign s_neg = i_neg;
        end else begin : g_next
            assign s_e   = r_e[k];
            assign s_b   = r_b[k];
            assign s_s   = r_s[k];
            assign s_q   = r_q[k];
            assign s_neg = r_neg[k];
        end

        always_comb begin
            n_t = (s_b <<< (B + 2)) - (s_b <<< 1)
                + (s_s <<< (2 * B + 2)) - (s_s <<< (B + 2)) + s_s;
            n_take = (n_t <= s_e);
        end

        always_ff @(posedge i_clk) begin
            r_s[k+1]   <= s_s;
            r_neg[k+1] <= s_neg;
            if (n_take) begin
                r_e[k+1] <= s_e - (s_b <<< (B + 2)) - (s_s <<< (2 * B + 2));
                r_b[k+1] <= s_b + (s_s <<< (B + 1));
                r_q[k+1] <= s_q | (NS'(1) << B);
            end else begin
                r_e[k+1] <= s_e;
                r_b[k+1] <= s_b;
                r_q[k+1] <= s_q;
            end
        end
    end

    assign o_mag = r_q[NS];
    assign o_neg = r_neg[NS];
endmodule

// ===== src/heightmap_normal_tangent.sv =====
// Top level: central-difference normal, tangent and texture coordinates per vertex.
// One vertex is taken every clock cycle (busy stays low); its result appears with
// o_valid for one cycle. The pipeline depth is set by the bit-per-stage inverse
// square root units (OUT_FRAC_BITS + 2 stages) plus difference, square, sum and
// output registers. The receiver cannot stall.
module heightmap_normal_tangent #(
    parameter int CELLS_PER_EDGE   = 32,
    parameter int HEIGHT_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_center,
    input  logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_left,
    input  logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_right,
    input  logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_back,
    input  logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_forward,
    input  logic [hnt_pkg::GRID_W-1:0]          i_grid_x,
    input  logic [hnt_pkg::GRID_W-1:0]          i_grid_z,
    output logic                                o_valid,
    output logic signed [hnt_pkg::SCOMP_W-1:0]  o_normal_x,
    output logic [hnt_pkg::UCOMP_W-1:0]         o_normal_y,
    output logic signed [hnt_pkg::SCOMP_W-1:0]  o_normal_z,
    output logic [hnt_pkg::UCOMP_W-1:0]         o_tangent_x,
    output logic signed [hnt_pkg::SCOMP_W-1:0]  o_tangent_y,
    output logic [hnt_pkg::UCOMP_W-1:0]         o_tex_u,
    output logic [hnt_pkg::UCOMP_W-1:0]         o_tex_v,
    output logic signed [hnt_pkg::HEIGHT_W-1:0] o_height_out
);
    localparam int NS  = hnt_pkg::OUT_FRAC_BITS + 2;
    localparam longint KV = longint'(2) << HEIGHT_FRAC_BITS;
    localparam logic [hnt_pkg::SUM_W-1:0] KK = hnt_pkg::SUM_W'(KV * KV);
    localparam int ONE = 1 << hnt_pkg::OUT_FRAC_BITS;
    localparam int NG  = 1 << hnt_pkg::GRID_W;

    logic [hnt_pkg::UCOMP_W-1:0] tex_lut [NG];
    for (genvar g = 0; g < NG; g++) begin : g_tex
        localparam int TV =
            ((g << hnt_pkg::OUT_FRAC_BITS) + CELLS_PER_EDGE / 2) / CELLS_PER_EDGE;
        localparam int TS = (TV > ONE) ? ONE : TV;
        assign tex_lut[g] = hnt_pkg::UCOMP_W'(TS);
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // stage 0: differences
    logic                                r_v0;
    logic signed [hnt_pkg::DIFF_W-1:0]   r_dr, r_db;
    logic signed [hnt_pkg::HEIGHT_W-1:0] r_h0;
    logic [hnt_pkg::UCOMP_W-1:0]         r_u0, r_w0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
        r_dr <= hnt_pkg::DIFF_W'(i_height_right) - hnt_pkg::DIFF_W'(i_height_left);
        r_db <= hnt_pkg::DIFF_W'(i_height_forward) - hnt_pkg::DIFF_W'(i_height_back);
        r_h0 <= i_height_center;
        r_u0 <= tex_lut[i_grid_x];
        r_w0 <= tex_lut[i_grid_z];
    end

    // stage 1: squares
    logic                                r_v1, r_drp1, r_drn1, r_dbp1;
    logic [hnt_pkg::SQ_W-1:0]            r_dr2, r_db2;
    logic signed [hnt_pkg::HEIGHT_W-1:0] r_h1;
    logic [hnt_pkg::UCOMP_W-1:0]         r_u1, r_w1;
    logic [hnt_pkg::DIFF_W-1:0]          n_adr, n_adb;

    always_comb begin
        n_adr = r_dr[hnt_pkg::DIFF_W-1] ? -r_dr : r_dr;
        n_adb = r_db[hnt_pkg::DIFF_W-1] ? -r_db : r_db;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_dr2  <= hnt_pkg::SQ_W'(n_adr) * hnt_pkg::SQ_W'(n_adr);
        r_db2  <= hnt_pkg::SQ_W'(n_adb) * hnt_pkg::SQ_W'(n_adb);
        r_drp1 <= (r_dr > 0);
        r_drn1 <= (r_dr < 0);
        r_dbp1 <= (r_db > 0);
        r_h1   <= r_h0;
        r_u1   <= r_u0;
        r_w1   <= r_w0;
    end

    // stage 2: length sums
    logic                                r_v2, r_drp2, r_drn2, r_dbp2;
    logic [hnt_pkg::SQ_W-1:0]            r_dr2b, r_db2b;
    logic [hnt_pkg::SUM_W-1:0]           r_sn, r_st;
    logic signed [hnt_pkg::HEIGHT_W-1:0] r_h2;
    logic [hnt_pkg::UCOMP_W-1:0]         r_u2, r_w2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sn   <= hnt_pkg::SUM_W'(r_dr2) + hnt_pkg::SUM_W'(r_db2) + KK;
        r_st   <= hnt_pkg::SUM_W'(r_dr2) + KK;
        r_dr2b <= r_dr2;
        r_db2b <= r_db2;
        r_drp2 <= r_drp1;
        r_drn2 <= r_drn1;
        r_dbp2 <= r_dbp1;
        r_h2   <= r_h1;
        r_u2   <= r_u1;
        r_w2   <= r_w1;
    end

    logic [NS-1:0] q_nx, q_ny, q_nz, q_tx, q_ty;
    logic          s_nx, s_ny, s_nz, s_tx, s_ty;

    hnt_unit #(.OUT_FRAC_BITS(hnt_pkg::OUT_FRAC_BITS)) u_nx (
        .i_clk(i_clk), .i_m2(r_dr2b), .i_s(r_sn), .i_neg(r_drp2),
        .o_mag(q_nx), .o_neg(s_nx));
    hnt_unit #(.OUT_FRAC_BITS(hnt_pkg::OUT_FRAC_BITS)) u_ny (
        .i_clk(i_clk), .i_m2(hnt_pkg::SQ_W'(KK)), .i_s(r_sn), .i_neg(1'b0),
        .o_mag(q_ny), .o_neg(s_ny));
    hnt_unit #(.OUT_FRAC_BITS(hnt_pkg::OUT_FRAC_BITS)) u_nz (
        .i_clk(i_clk), .i_m2(r_db2b), .i_s(r_sn), .i_neg(r_dbp2),
        .o_mag(q_nz), .o_neg(s_nz));
    hnt_unit #(.OUT_FRAC_BITS(hnt_pkg::OUT_FRAC_BITS)) u_tx (
        .i_clk(i_clk), .i_m2(hnt_pkg::SQ_W'(KK)), .i_s(r_st), .i_neg(1'b0),
        .o_mag(q_tx), .o_neg(s_tx));
    hnt_unit #(.OUT_FRAC_BITS(hnt_pkg::OUT_FRAC_BITS)) u_ty (
        .i_clk(i_clk), .i_m2(r_dr2b), .i_s(r_st), .i_neg(r_drn2),
        .o_mag(q_ty), .o_neg(s_ty));

    // sideband delay matching the unit depth
    logic                                r_dv [NS];
    logic signed [hnt_pkg::HEIGHT_W-1:0] r_dh [NS];
    logic [hnt_pkg::UCOMP_W-1:0]         r_du [NS];
    logic [hnt_pkg::UCOMP_W-1:0]         r_dw [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v2;
            for (int i = 1; i < NS; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
        r_dh[0] <= r_h2;
        r_du[0] <= r_u2;
        r_dw[0] <= r_w2;
        for (int i = 1; i < NS; i++) begin
            r_dh[i] <= r_dh[i-1];
            r_du[i] <= r_du[i-1];
            r_dw[i] <= r_dw[i-1];
        end
    end

    logic [31:0] n_nx, n_ny, n_nz, n_tx, n_ty;

    always_comb begin
        n_nx = s_nx ? -{{(32-NS){1'b0}}, q_nx} : {{(32-NS){1'b0}}, q_nx};
        n_ny = s_ny ? -{{(32-NS){1'b0}}, q_ny} : {{(32-NS){1'b0}}, q_ny};
        n_nz = s_nz ? -{{(32-NS){1'b0}}, q_nz} : {{(32-NS){1'b0}}, q_nz};
        n_tx = s_tx ? -{{(32-NS){1'b0}}, q_tx} : {{(32-NS){1'b0}}, q_tx};
        n_ty = s_ty ? -{{(32-NS){1'b0}}, q_ty} : {{(32-NS){1'b0}}, q_ty};
    end

    // output word register
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv[NS-1];
        end
        o_normal_x   <= n_nx[hnt_pkg::SCOMP_W-1:0];
        o_normal_y   <= n_ny[hnt_pkg::UCOMP_W-1:0];
        o_normal_z   <= n_nz[hnt_pkg::SCOMP_W-1:0];
        o_tangent_x  <= n_tx[hnt_pkg::UCOMP_W-1:0];
        o_tangent_y  <= n_ty[hnt_pkg::SCOMP_W-1:0];
        o_tex_u      <= r_du[NS-1];
        o_tex_v      <= r_dw[NS-1];
        o_height_out <= r_dh[NS-1];
    end

    assign o_valid = r_valid;
endmodule

// ===== sim/heightmap_normal_tangent_tb.sv =====
// Testbench for heightmap_normal_tangent: directed and random vertices, bit-exact checks.
`timescale 1ns / 1ps

module heightmap_normal_tangent_tb;
    localparam int N_RANDOM   = 1030;
    localparam int CYCLE_MAX  = 200000;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic [hnt_pkg::HEIGHT_W-1:0] hc;
        logic [hnt_pkg::HEIGHT_W-1:0] hl;
        logic [hnt_pkg::HEIGHT_W-1:0] hr;
        logic [hnt_pkg::HEIGHT_W-1:0] hb;
        logic [hnt_pkg::HEIGHT_W-1:0] hf;
        logic [hnt_pkg::GRID_W-1:0]   gx;
        logic [hnt_pkg::GRID_W-1:0]   gz;
    } t_vertex;

    typedef struct packed {
        logic [hnt_pkg::SCOMP_W-1:0]  nx;
        logic [hnt_pkg::UCOMP_W-1:0]  ny;
        logic [hnt_pkg::SCOMP_W-1:0]  nz;
        logic [hnt_pkg::UCOMP_W-1:0]  tx;
        logic [hnt_pkg::SCOMP_W-1:0]  ty;
        logic [hnt_pkg::UCOMP_W-1:0]  u;
        logic [hnt_pkg::UCOMP_W-1:0]  v;
        logic [hnt_pkg::HEIGHT_W-1:0] h;
    } t_shade;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_center, i_height_left, i_height_right;
    logic signed [hnt_pkg::HEIGHT_W-1:0] i_height_back, i_height_forward;
    logic [hnt_pkg::GRID_W-1:0] i_grid_x, i_grid_z;
    logic o_valid;
    logic signed [hnt_pkg::SCOMP_W-1:0] o_normal_x, o_normal_z, o_tangent_y;
    logic [hnt_pkg::UCOMP_W-1:0] o_normal_y, o_tangent_x, o_tex_u, o_tex_v;
    logic signed [hnt_pkg::HEIGHT_W-1:0] o_height_out;

    t_vertex vertex_q[$];
    t_shade  shade_q[$];
    int      n_total;
    int      n_sent;
    int      n_err;
    int      cycles;
    bit      taken;

    heightmap_normal_tangent DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_height_center(i_height_center), .i_height_left(i_height_left),
        .i_height_right(i_height_right), .i_height_back(i_height_back),
        .i_height_forward(i_height_forward), .i_grid_x(i_grid_x), .i_grid_z(i_grid_z),
        .o_valid(o_valid), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v), .o_height_out(o_height_out)
    );

    function automatic logic [15:0] unit_len(logic [17:0] m, logic [35:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [17:0]  c;
        logic [17:0]  t;
        logic [15:0]  q;
        q   = '0;
        rhs = 128'(m) * 128'(m) * (128'd1 << 30);
        for (int b = 15; b >= 0; b--) begin
            c   = 18'(q) | (18'd1 << b);
            t   = 18'(2 * c - 1);
            lhs = 128'(t) * 128'(t) * 128'(s);
            if (lhs <= rhs) q = c[15:0];
        end
        return q;
    endfunction

    function automatic logic [15:0] signed_len(longint a, logic [35:0] s);
        logic [15:0] q;
        q = unit_len((a < 0) ? 18'(-a) : 18'(a), s);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic [14:0] grid_coord(logic [hnt_pkg::GRID_W-1:0] g);
        int t;
        t = ((int'(g) << 14) + 16) / 32;
        return (t > 16384) ? 15'd16384 : 15'(t);
    endfunction

    function automatic t_shade shade_vertex(t_vertex w);
        longint      dr;
        longint      db;
        logic [35:0] sn;
        logic [35:0] st;
        t_shade      r;
        dr = longint'($signed(w.hr)) - longint'($signed(w.hl));
        db = longint'($signed(w.hf)) - longint'($signed(w.hb));
        st = 36'(dr * dr + 512 * 512);
        sn = st + 36'(db * db);
        r.nx = signed_len(-dr, sn);
        r.ny = 15'(unit_len(18'd512, sn));
        r.nz = signed_len(-db, sn);
        r.tx = 15'(unit_len(18'd512, st));
        r.ty = signed_len(dr, st);
        r.u  = grid_coord(w.gx);
        r.v  = grid_coord(w.gz);
        r.h  = w.hc;
        return r;
    endfunction

    function automatic t_vertex mk(int c, int l, int r, int b, int f, int x, int z);
        t_vertex w;
        w = {16'(c), 16'(l), 16'(r), 16'(b), 16'(f), 6'(x), 6'(z)};
        return w;
    endfunction

    task automatic add_vertex(t_vertex w);
        vertex_q = {vertex_q, w};
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        int  pct;
        bit  idle;
        t_vertex w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            pct  = (n_sent < n_total / 3) ? 18 : (n_sent < 2 * n_total / 3) ? 58 : 0;
            idle = ($urandom_range(99) < pct);
            if (vertex_q.size() > 0 && !idle) begin
                w = vertex_q.pop_front();
                {i_height_center, i_height_left, i_height_right, i_height_back,
                 i_height_forward, i_grid_x, i_grid_z} <= w;
                start  <= 1'b1;
                n_sent <= n_sent + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_shade got;
        t_shade want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            got = {o_normal_x, o_normal_y, o_normal_z, o_tangent_x, o_tangent_y,
                   o_tex_u, o_tex_v, o_height_out};
            if (shade_q.size() == 0) begin
                n_err = n_err + 1;
                if (n_err <= 10) $display("unexpected word %h", got);
            end else begin
                want = shade_q.pop_front();
                if (got !== want) begin
                    n_err = n_err + 1;
                    if (n_err <= 10) begin
                        $display("mismatch nx %0d/%0d ny %0d/%0d nz %0d/%0d tx %0d/%0d",
                            $signed(want.nx), $signed(got.nx), want.ny, got.ny,
                            $signed(want.nz), $signed(got.nz), want.tx, got.tx);
                        $display("         ty %0d/%0d u %0d/%0d v %0d/%0d h %0d/%0d",
                            $signed(want.ty), $signed(got.ty), want.u, got.u,
                            want.v, got.v, $signed(want.h), $signed(got.h));
                    end
                end
            end
        end
        if (i_rst_n && start && !busy)
            shade_q = {shade_q, shade_vertex({i_height_center, i_height_left,
                i_height_right, i_height_back, i_height_forward, i_grid_x, i_grid_z})};
    end

    initial begin
        int base;
        int spread;
        i_rst_n = 1'b0;
        start = 1'b0;
        taken = 1'b0;
        n_sent = 0;
        n_err = 0;
        cycles = 0;
        {i_height_center, i_height_left, i_height_right, i_height_back,
         i_height_forward, i_grid_x, i_grid_z} = '0;

        add_vertex(mk(0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(32767, -32768, 32767, -32768, 32767, 32, 32));
        add_vertex(mk(-32768, 32767, -32768, 32767, -32768, 63, 63));
        add_vertex(mk(-1, -32768, 32767, 0, 0, 33, 1));
        add_vertex(mk(1, 0, 0, 32767, -32768, 1, 33));
        add_vertex(mk(256, 0, 512, 0, 512, 16, 31));
        add_vertex(mk(-256, 512, 0, 512, 0, 31, 16));
        add_vertex(mk(100, 0, 1, 0, -1, 2, 30));
        add_vertex(mk(-100, 0, 1024, 0, 0, 0, 32));
        add_vertex(mk(5, 0, 0, 0, -1024, 32, 0));
        add_vertex(mk(21845, -21846, 21845, 21845, -21846, 42, 21));
        add_vertex(mk(-21846, 100, 100, -7, 7, 21, 42));
        add_vertex(mk(12345, 32767, 32767, -32768, -32768, 63, 0));
        add_vertex(mk(-12345, 0, 1, 1, 0, 0, 63));
        add_vertex(mk(7, 0, 0, 0, 32767, 15, 17));
        add_vertex(mk(-7, 0, -32768, 0, 0, 5, 27));
        for (int i = 0; i < N_RANDOM; i++) begin
            base   = $urandom_range(65535) - 32768;
            spread = (i % 4 == 0) ? 65535 : (i % 4 == 1) ? 2048 : 256;
            if (spread == 65535)
                add_vertex(mk($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(63), $urandom_range(63)));
            else
                add_vertex(mk(base,
                    base + $urandom_range(spread) - spread / 2,
                    base + $urandom_range(spread) - spread / 2,
                    base + $urandom_range(spread) - spread / 2,
                    base + $urandom_range(spread) - spread / 2,
                    $urandom_range(32), $urandom_range(32)));
        end
        n_total = vertex_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (vertex_q.size() == 0 && !start);
        wait (shade_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== heightmap_normal_tangent.f =====
src/hnt_pkg.sv
src/hnt_unit.sv
src/heightmap_normal_tangent.sv
sim/heightmap_normal_tangent_tb.sv
